@@ rtl/krt_pkg.sv @@
// Package for the keyed record table: shared constants, command and status
// codes, the request and result records, and the sequencer state type.
// No dependencies.
package krt_pkg;

   localparam int unsigned TABLE_DEPTH_DEF = 64;
   localparam int unsigned KEY_BYTES_DEF   = 8;
   localparam int unsigned KEY_W           = 64;
   localparam int unsigned MATCH_W         = 7;
   localparam int unsigned QUEUE_DEPTH     = 2;
   localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_LIST   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_ADDED    = 3'd0,
      ST_FULL     = 3'd1,
      ST_REMOVED  = 3'd2,
      ST_SEARCH   = 3'd3,
      ST_LISTED   = 3'd4,
      ST_NO_MATCH = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE   = 3'd0,
      S_ADD    = 3'd1,
      S_SCAN   = 3'd2,
      S_MOVE   = 3'd3,
      S_FINISH = 3'd4
   } state_type;

   typedef struct packed {
      cmd_type          cmd;
      logic [KEY_W-1:0] name_key;
      logic [KEY_W-1:0] color_key;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic               found;
      logic [MATCH_W-1:0] match_count;
      logic [KEY_W-1:0]   out_name;
      logic [KEY_W-1:0]   out_color;
      logic               last;
   } rsp_type;

endpackage

@@ rtl/krt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Read-first on a same-address collision. No dependencies.
module krt_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/krt_front.sv @@
// Front end of the keyed record table: accepts requests, trims keys to the
// configured byte count, and holds them in a short queue for the back end.
// Depends on krt_pkg.
module krt_front #(
   parameter int unsigned KEY_BYTES = krt_pkg::KEY_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [1:0]                req_cmd,
   input  logic [krt_pkg::KEY_W-1:0] req_name_key,
   input  logic [krt_pkg::KEY_W-1:0] req_color_key,
   output logic                      q_valid,
   input  logic                      q_pop,
   output krt_pkg::req_type          q_head
);

   krt_pkg::req_type                 slot_ff [krt_pkg::QUEUE_DEPTH];
   krt_pkg::req_type                 entry;
   logic [krt_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [krt_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [krt_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   // trim keys: bytes above KEY_BYTES read as zero
   always_comb begin
      entry.cmd = krt_pkg::cmd_type'(req_cmd);
      for (int b = 0; b < 8; b++) begin
         entry.name_key[8*b +: 8]  = (b < KEY_BYTES) ? req_name_key[8*b +: 8]  : 8'h00;
         entry.color_key[8*b +: 8] = (b < KEY_BYTES) ? req_color_key[8*b +: 8] : 8'h00;
      end
   end

   assign req_full = (count_ff == krt_pkg::QCNT_W'(krt_pkg::QUEUE_DEPTH));
   assign q_valid  = (count_ff != '0);
   assign q_head   = slot_ff[rd_ptr_ff];
   assign do_push  = req_push && !req_full;
   assign do_pop   = q_pop && q_valid;

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the request payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

@@ rtl/krt_back.sv @@
// Back end of the keyed record table: runs each queued request against the
// name and color memories and delivers results through an output register.
// Depends on krt_pkg and krt_ram.
module krt_back #(
   parameter int unsigned TABLE_DEPTH = krt_pkg::TABLE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  krt_pkg::req_type q_head,
   output logic             q_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output krt_pkg::rsp_type rsp
);

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

   krt_pkg::state_type        state_ff, state_in;
   krt_pkg::req_type          req_ff, req_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             bound_ff, bound_in;
   logic [CW-1:0]             idx_ff, idx_in;
   logic [CW-1:0]             hits_ff, hits_in;
   logic                      hold_valid_ff, hold_valid_in;
   krt_pkg::rsp_type          hold_ff, hold_in;
   logic                      out_valid_ff, out_valid_in;
   krt_pkg::rsp_type          out_ff, out_in;

   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic [AW-1:0]             rd_addr;
   logic [krt_pkg::KEY_W-1:0] name_wdata, color_wdata;
   logic [krt_pkg::KEY_W-1:0] name_rd, color_rd;
   logic                      slot_free;
   logic                      is_match;
   logic                      push;
   krt_pkg::rsp_type          push_data;

   krt_ram #(.WIDTH(krt_pkg::KEY_W), .DEPTH(TABLE_DEPTH)) u_name_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (name_wdata),
      .rd_addr (rd_addr),
      .rd_data (name_rd)
   );

   krt_ram #(.WIDTH(krt_pkg::KEY_W), .DEPTH(TABLE_DEPTH)) u_color_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (color_wdata),
      .rd_addr (rd_addr),
      .rd_data (color_rd)
   );

   assign slot_free = !out_valid_ff || rsp_pop;
   assign is_match  = (req_ff.cmd == krt_pkg::CMD_LIST) ?
                      (color_rd == req_ff.color_key) : (name_rd == req_ff.name_key);

   // sequencer: next state, memory control and result pushes
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      count_in      = count_ff;
      bound_in      = bound_ff;
      idx_in        = idx_ff;
      hits_in       = hits_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      q_pop         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[AW-1:0];
      name_wdata    = name_rd;
      color_wdata   = color_rd;
      push          = 1'b0;
      push_data     = '0;

      unique case (state_ff)
         krt_pkg::S_IDLE: begin
            if (q_valid) begin
               q_pop         = 1'b1;
               req_in        = q_head;
               idx_in        = '0;
               bound_in      = count_ff;
               hits_in       = '0;
               hold_valid_in = 1'b0;
               state_in      = (q_head.cmd == krt_pkg::CMD_ADD) ?
                               krt_pkg::S_ADD : krt_pkg::S_SCAN;
            end
         end
         krt_pkg::S_ADD: begin
            if (slot_free) begin
               push           = 1'b1;
               push_data.last = 1'b1;
               if (count_ff == CW'(TABLE_DEPTH)) begin
                  push_data.status = krt_pkg::ST_FULL;
               end else begin
                  push_data.status    = krt_pkg::ST_ADDED;
                  push_data.out_color = req_ff.color_key;
                  wr_en               = 1'b1;
                  wr_addr             = count_ff[AW-1:0];
                  name_wdata          = req_ff.name_key;
                  color_wdata         = req_ff.color_key;
                  count_in            = count_ff + 1'b1;
               end
               state_in = krt_pkg::S_IDLE;
            end
         end
         krt_pkg::S_SCAN: begin
            if (idx_ff >= bound_ff) begin
               state_in = krt_pkg::S_FINISH;
            end else if (!is_match) begin
               idx_in = idx_ff + 1'b1;
            end else if (req_ff.cmd == krt_pkg::CMD_SEARCH) begin
               hits_in = hits_ff + 1'b1;
               idx_in  = idx_ff + 1'b1;
            end else if (!hold_valid_ff || slot_free) begin
               // release the held result, keep the new one back
               push          = hold_valid_ff;
               push_data     = hold_ff;
               hold_valid_in = 1'b1;
               hold_in       = '0;
               if (req_ff.cmd == krt_pkg::CMD_REMOVE) begin
                  hold_in.status    = krt_pkg::ST_REMOVED;
                  hold_in.out_name  = req_ff.name_key;
                  hold_in.out_color = color_rd;
                  bound_in          = bound_ff - 1'b1;
                  state_in          = krt_pkg::S_MOVE;
               end else begin
                  hold_in.status   = krt_pkg::ST_LISTED;
                  hold_in.out_name = name_rd;
                  idx_in           = idx_ff + 1'b1;
               end
            end
         end
         krt_pkg::S_MOVE: begin
            // copy the last entry into the freed slot
            wr_en    = 1'b1;
            idx_in   = idx_ff + 1'b1;
            state_in = krt_pkg::S_SCAN;
         end
         krt_pkg::S_FINISH: begin
            if (slot_free) begin
               push = 1'b1;
               if (hold_valid_ff) begin
                  push_data = hold_ff;
               end else if (req_ff.cmd == krt_pkg::CMD_SEARCH) begin
                  push_data.status      = krt_pkg::ST_SEARCH;
                  push_data.found       = (hits_ff != '0);
                  push_data.match_count = krt_pkg::MATCH_W'(hits_ff);
               end else begin
                  push_data.status = krt_pkg::ST_NO_MATCH;
               end
               push_data.last = 1'b1;
               hold_valid_in  = 1'b0;
               count_in       = bound_ff;
               state_in       = krt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = krt_pkg::S_IDLE;
         end
      endcase
   end

   // read the moved entry while moving, else the next scan index
   assign rd_addr = (state_in == krt_pkg::S_MOVE) ? bound_in[AW-1:0] : idx_in[AW-1:0];

   // load or drain the output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (push) begin
         out_valid_in = 1'b1;
         out_in       = push_data;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= krt_pkg::S_IDLE;
         count_ff      <= '0;
         bound_ff      <= '0;
         idx_ff        <= '0;
         hits_ff       <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         bound_ff      <= bound_in;
         idx_ff        <= idx_in;
         hits_ff       <= hits_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // hold payload registers
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      hold_ff <= hold_in;
      out_ff  <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp       = out_ff;

endmodule

@@ rtl/keyed_record_table.sv @@
// Top level of the keyed record table: joins krt_front and krt_back (krt_pkg).
// The back end runs one request at a time: an add writes its entry and reports, while
// remove, search and list scan every stored entry (at most TABLE_DEPTH) before their
// last result; the queue in front takes new requests meanwhile, and a result that is
// not taken stalls the back end.
// Reset clears the entry count, queue and output register; memories are not cleared.
module keyed_record_table #(
   parameter int unsigned TABLE_DEPTH = krt_pkg::TABLE_DEPTH_DEF,
   parameter int unsigned KEY_BYTES   = krt_pkg::KEY_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [1:0]                  req_cmd,
   input  logic [krt_pkg::KEY_W-1:0]   req_name_key,
   input  logic [krt_pkg::KEY_W-1:0]   req_color_key,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [2:0]                  rsp_status,
   output logic                        rsp_found,
   output logic [krt_pkg::MATCH_W-1:0] rsp_match_count,
   output logic [krt_pkg::KEY_W-1:0]   rsp_out_name,
   output logic [krt_pkg::KEY_W-1:0]   rsp_out_color,
   output logic                        rsp_last
);

   logic             q_valid;
   logic             q_pop;
   krt_pkg::req_type q_head;
   krt_pkg::rsp_type rsp;

   krt_front #(.KEY_BYTES(KEY_BYTES)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_cmd       (req_cmd),
      .req_name_key  (req_name_key),
      .req_color_key (req_color_key),
      .q_valid       (q_valid),
      .q_pop         (q_pop),
      .q_head        (q_head)
   );

   krt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   // unpack the result record onto the ports
   assign rsp_status      = rsp.status;
   assign rsp_found       = rsp.found;
   assign rsp_match_count = rsp.match_count;
   assign rsp_out_name    = rsp.out_name;
   assign rsp_out_color   = rsp.out_color;
   assign rsp_last        = rsp.last;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for keyed_record_table: drives add, remove, search and list requests
// through the push/full queue and checks every result against a table predictor.
// Depends on krt_pkg and the keyed_record_table RTL.
module tb_top;

   localparam int unsigned DEPTH          = krt_pkg::TABLE_DEPTH_DEF;
   localparam int unsigned HOLD_OFF_LEN   = 400;
   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned DRAIN_CYCLES   = 150;

   localparam logic [krt_pkg::KEY_W-1:0] KEY_ZERO    = '0;
   localparam logic [krt_pkg::KEY_W-1:0] KEY_ONES    = '1;
   localparam logic [krt_pkg::KEY_W-1:0] NAME_ALPHA  = "alpha";
   localparam logic [krt_pkg::KEY_W-1:0] NAME_BETA   = "beta";
   localparam logic [krt_pkg::KEY_W-1:0] NAME_GAMMA  = "gamma";
   localparam logic [krt_pkg::KEY_W-1:0] COLOR_RED   = "red";
   localparam logic [krt_pkg::KEY_W-1:0] COLOR_BLUE  = "blue";
   localparam logic [krt_pkg::KEY_W-1:0] COLOR_GREEN = "green";

   typedef struct {
      krt_pkg::cmd_type          cmd;
      logic [krt_pkg::KEY_W-1:0] name_key;
      logic [krt_pkg::KEY_W-1:0] color_key;
      bit                        typed;
      krt_pkg::status_type       status;
      logic [krt_pkg::KEY_W-1:0] out_color;
   } stim_row_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_push = 1'b0;
   logic                        req_full;
   logic [1:0]                  req_cmd = krt_pkg::CMD_ADD;
   logic [krt_pkg::KEY_W-1:0]   req_name_key = '0;
   logic [krt_pkg::KEY_W-1:0]   req_color_key = '0;
   logic                        rsp_empty;
   logic                        rsp_pop = 1'b0;
   logic [2:0]                  rsp_status;
   logic                        rsp_found;
   logic [krt_pkg::MATCH_W-1:0] rsp_match_count;
   logic [krt_pkg::KEY_W-1:0]   rsp_out_name;
   logic [krt_pkg::KEY_W-1:0]   rsp_out_color;
   logic                        rsp_last;

   // predictor copy of the table
   logic [krt_pkg::KEY_W-1:0] table_name [DEPTH];
   logic [krt_pkg::KEY_W-1:0] table_color [DEPTH];
   int unsigned               table_count = 0;

   krt_pkg::rsp_type command_results[$];
   krt_pkg::rsp_type outstanding_results[$];
   int unsigned      error_count = 0;
   int unsigned      sender_idle_pct = 23;
   int unsigned      receiver_idle_pct = 60;
   bit               hold_off_req = 1'b0;
   int unsigned      hold_off_left = 0;
   int unsigned      quiet_cycles = 0;

   logic [krt_pkg::KEY_W-1:0] name_pool [4];
   logic [krt_pkg::KEY_W-1:0] color_pool [4];

   // directed requests; typed rows carry a single obvious result
   stim_row_type directed_rows [22] = '{
      '{krt_pkg::CMD_SEARCH, NAME_ALPHA, KEY_ZERO, 1'b1, krt_pkg::ST_SEARCH, KEY_ZERO},
      '{krt_pkg::CMD_REMOVE, NAME_ALPHA, KEY_ZERO, 1'b1, krt_pkg::ST_NO_MATCH, KEY_ZERO},
      '{krt_pkg::CMD_LIST, KEY_ZERO, COLOR_RED, 1'b1, krt_pkg::ST_NO_MATCH, KEY_ZERO},
      '{krt_pkg::CMD_ADD, KEY_ZERO, KEY_ZERO, 1'b1, krt_pkg::ST_ADDED, KEY_ZERO},
      '{krt_pkg::CMD_ADD, KEY_ONES, KEY_ONES, 1'b1, krt_pkg::ST_ADDED, KEY_ONES},
      '{krt_pkg::CMD_ADD, NAME_ALPHA, COLOR_RED, 1'b1, krt_pkg::ST_ADDED, COLOR_RED},
      '{krt_pkg::CMD_ADD, NAME_BETA, COLOR_RED, 1'b1, krt_pkg::ST_ADDED, COLOR_RED},
      '{krt_pkg::CMD_ADD, NAME_ALPHA, COLOR_BLUE, 1'b1, krt_pkg::ST_ADDED, COLOR_BLUE},
      '{krt_pkg::CMD_ADD, NAME_ALPHA, COLOR_RED, 1'b1, krt_pkg::ST_ADDED, COLOR_RED},
      '{krt_pkg::CMD_SEARCH, NAME_ALPHA, KEY_ONES, 1'b0, krt_pkg::ST_SEARCH, KEY_ZERO},
      '{krt_pkg::CMD_SEARCH, KEY_ZERO, KEY_ZERO, 1'b0, krt_pkg::ST_SEARCH, KEY_ZERO},
      '{krt_pkg::CMD_LIST, KEY_ONES, COLOR_RED, 1'b0, krt_pkg::ST_LISTED, KEY_ZERO},
      '{krt_pkg::CMD_LIST, KEY_ZERO, KEY_ONES, 1'b0, krt_pkg::ST_LISTED, KEY_ZERO},
      '{krt_pkg::CMD_LIST, NAME_BETA, KEY_ZERO, 1'b0, krt_pkg::ST_LISTED, KEY_ZERO},
      // alpha moved in from the tail is skipped, one alpha survives
      '{krt_pkg::CMD_REMOVE, NAME_ALPHA, KEY_ZERO, 1'b0, krt_pkg::ST_REMOVED, KEY_ZERO},
      '{krt_pkg::CMD_SEARCH, NAME_ALPHA, KEY_ZERO, 1'b0, krt_pkg::ST_SEARCH, KEY_ZERO},
      '{krt_pkg::CMD_REMOVE, KEY_ONES, KEY_ONES, 1'b0, krt_pkg::ST_REMOVED, KEY_ZERO},
      '{krt_pkg::CMD_REMOVE, KEY_ZERO, KEY_ZERO, 1'b0, krt_pkg::ST_REMOVED, KEY_ZERO},
      '{krt_pkg::CMD_LIST, NAME_ALPHA, COLOR_BLUE, 1'b0, krt_pkg::ST_LISTED, KEY_ZERO},
      '{krt_pkg::CMD_REMOVE, NAME_GAMMA, KEY_ONES, 1'b1, krt_pkg::ST_NO_MATCH, KEY_ZERO},
      '{krt_pkg::CMD_LIST, NAME_GAMMA, COLOR_GREEN, 1'b1, krt_pkg::ST_NO_MATCH, KEY_ZERO},
      '{krt_pkg::CMD_SEARCH, NAME_BETA, KEY_ZERO, 1'b0, krt_pkg::ST_SEARCH, KEY_ZERO}
   };

   keyed_record_table DUT (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_cmd         (req_cmd),
      .req_name_key    (req_name_key),
      .req_color_key   (req_color_key),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_match_count (rsp_match_count),
      .rsp_out_name    (rsp_out_name),
      .rsp_out_color   (rsp_out_color),
      .rsp_last        (rsp_last)
   );

   always #5 clock = ~clock;

   function automatic krt_pkg::rsp_type make_rsp(input krt_pkg::status_type status,
                                                 input logic found,
                                                 input logic [krt_pkg::MATCH_W-1:0] count,
                                                 input logic [krt_pkg::KEY_W-1:0] name_key,
                                                 input logic [krt_pkg::KEY_W-1:0] color_key);
      krt_pkg::rsp_type r;
      r.status      = status;
      r.found       = found;
      r.match_count = count;
      r.out_name    = name_key;
      r.out_color   = color_key;
      r.last        = 1'b0;
      return r;
   endfunction

   // Compute the results of one request and update the table copy
   task automatic apply_command(input krt_pkg::cmd_type cmd,
                                input logic [krt_pkg::KEY_W-1:0] name_key,
                                input logic [krt_pkg::KEY_W-1:0] color_key);
      int unsigned bound;
      int unsigned hits;
      int unsigned i;
      bound = table_count;
      hits  = 0;
      command_results.delete();
      case (cmd)
         krt_pkg::CMD_ADD: begin
            if (bound >= DEPTH) begin
               command_results.push_back(make_rsp(krt_pkg::ST_FULL, 1'b0, '0, '0, '0));
            end else begin
               table_name[bound]  = name_key;
               table_color[bound] = color_key;
               table_count        = bound + 1;
               command_results.push_back(make_rsp(krt_pkg::ST_ADDED, 1'b0, '0, '0,
                                                  color_key));
            end
         end
         krt_pkg::CMD_REMOVE: begin
            // swap the tail into each hit; the moved-in entry is not rechecked
            for (i = 0; i < bound; i++) begin
               if (table_name[i] == name_key) begin
                  bound--;
                  command_results.push_back(make_rsp(krt_pkg::ST_REMOVED, 1'b0, '0,
                                                     name_key, table_color[i]));
                  table_name[i]  = table_name[bound];
                  table_color[i] = table_color[bound];
               end
            end
            table_count = bound;
         end
         krt_pkg::CMD_SEARCH: begin
            for (i = 0; i < bound; i++)
               if (table_name[i] == name_key) hits++;
            command_results.push_back(make_rsp(krt_pkg::ST_SEARCH, hits != 0,
                                               krt_pkg::MATCH_W'(hits), '0, '0));
         end
         default: begin
            for (i = 0; i < bound; i++)
               if (table_color[i] == color_key)
                  command_results.push_back(make_rsp(krt_pkg::ST_LISTED, 1'b0, '0,
                                                     table_name[i], '0));
         end
      endcase
      if (command_results.size() == 0)
         command_results.push_back(make_rsp(krt_pkg::ST_NO_MATCH, 1'b0, '0, '0, '0));
      command_results[command_results.size() - 1].last = 1'b1;
   endtask

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      error_count++;
   endtask

   task automatic compare_field(input string field, input logic [krt_pkg::KEY_W-1:0] got,
                                input logic [krt_pkg::KEY_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h want %h", field, got, want));
   endtask

   // Offer one request, hold it until accepted, then record what it should produce
   task automatic send_request(input krt_pkg::cmd_type cmd,
                               input logic [krt_pkg::KEY_W-1:0] name_key,
                               input logic [krt_pkg::KEY_W-1:0] color_key, input bit typed,
                               input krt_pkg::rsp_type typed_rsp);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_push      <= 1'b1;
      req_cmd       <= cmd;
      req_name_key  <= name_key;
      req_color_key <= color_key;
      @(posedge clock);
      while (req_full) @(posedge clock);
      apply_command(cmd, name_key, color_key);
      if (typed) outstanding_results.push_back(typed_rsp);
      else foreach (command_results[k]) outstanding_results.push_back(command_results[k]);
   endtask

   task automatic send_item(input krt_pkg::cmd_type cmd,
                            input logic [krt_pkg::KEY_W-1:0] name_key,
                            input logic [krt_pkg::KEY_W-1:0] color_key);
      send_request(cmd, name_key, color_key, 1'b0,
                   make_rsp(krt_pkg::ST_ADDED, 1'b0, '0, '0, '0));
   endtask

   // Mostly pooled keys so requests hit stored entries; the rest fully random
   function automatic logic [krt_pkg::KEY_W-1:0] pick_key(input bit from_names);
      if ($urandom_range(3) == 0) return {$urandom, $urandom};
      return from_names ? name_pool[$urandom_range(3)] : color_pool[$urandom_range(3)];
   endfunction

   task automatic send_random(input int unsigned count);
      int unsigned n;
      int unsigned pick;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 40)      send_item(krt_pkg::CMD_ADD, pick_key(1'b1), pick_key(1'b0));
         else if (pick < 60) send_item(krt_pkg::CMD_REMOVE, pick_key(1'b1), pick_key(1'b0));
         else if (pick < 80) send_item(krt_pkg::CMD_SEARCH, pick_key(1'b1), pick_key(1'b0));
         else                send_item(krt_pkg::CMD_LIST, pick_key(1'b1), pick_key(1'b0));
      end
   endtask

   // Check each accepted result, then decide whether to pop next cycle
   initial begin
      krt_pkg::rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            if (outstanding_results.size() == 0) begin
               report_mismatch($sformatf("result with nothing outstanding, status %0d",
                                         rsp_status));
            end else begin
               want = outstanding_results.pop_front();
               compare_field("status", krt_pkg::KEY_W'(rsp_status),
                             krt_pkg::KEY_W'(want.status));
               compare_field("found", krt_pkg::KEY_W'(rsp_found),
                             krt_pkg::KEY_W'(want.found));
               compare_field("match_count", krt_pkg::KEY_W'(rsp_match_count),
                             krt_pkg::KEY_W'(want.match_count));
               compare_field("out_name", rsp_out_name, want.out_name);
               compare_field("out_color", rsp_out_color, want.out_color);
               compare_field("last", krt_pkg::KEY_W'(rsp_last), krt_pkg::KEY_W'(want.last));
            end
         end
         if (hold_off_left != 0) begin
            hold_off_left--;
            rsp_pop <= 1'b0;
         end else if (hold_off_req) begin
            // hold off for a long stretch so the block fills and stalls its input
            hold_off_req  = 1'b0;
            hold_off_left = HOLD_OFF_LEN;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   // End the run when no handshake happens for too long
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no handshake for %0d cycles, %0d results outstanding",
                     $realtime, WATCHDOG_LIMIT, outstanding_results.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      int unsigned k;
      krt_pkg::rsp_type typed_rsp;
      for (k = 0; k < 4; k++) begin
         name_pool[k]  = {$urandom, $urandom};
         color_pool[k] = {$urandom, $urandom};
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table; sender idles 23 of 100, receiver 60
      foreach (directed_rows[r]) begin
         typed_rsp = make_rsp(directed_rows[r].status, 1'b0, '0, '0,
                              directed_rows[r].out_color);
         typed_rsp.last = 1'b1;
         send_request(directed_rows[r].cmd, directed_rows[r].name_key,
                      directed_rows[r].color_key, directed_rows[r].typed, typed_rsp);
      end
      send_random(12);

      sender_idle_pct   = 60;
      receiver_idle_pct = 23;
      send_random(12);

      // no idling: fill the table under a receiver hold-off, overflow it,
      // then scan the full table
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      hold_off_req      = 1'b1;
      while (table_count < DEPTH)
         send_item(krt_pkg::CMD_ADD, name_pool[$urandom_range(1)], color_pool[0]);
      send_item(krt_pkg::CMD_ADD, name_pool[2], color_pool[1]);
      send_item(krt_pkg::CMD_ADD, KEY_ONES, KEY_ONES);
      send_item(krt_pkg::CMD_LIST, name_pool[3], color_pool[0]);
      send_item(krt_pkg::CMD_SEARCH, name_pool[0], color_pool[1]);
      send_item(krt_pkg::CMD_REMOVE, name_pool[1], color_pool[2]);
      send_item(krt_pkg::CMD_LIST, name_pool[0], color_pool[0]);
      send_item(krt_pkg::CMD_REMOVE, name_pool[0], color_pool[3]);
      send_item(krt_pkg::CMD_SEARCH, name_pool[0], color_pool[0]);
      send_random(6);

      // drain, then allow for any stray result
      req_push <= 1'b0;
      while (outstanding_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
